// File: hw/rtl/array_doubly_linked_list_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the array doubly linked list
// Concurrent checks on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ARRAY_DOUBLY_LINKED_LIST_MACROS_SVH
`define ARRAY_DOUBLY_LINKED_LIST_MACROS_SVH

// same-cycle implication
`define ADLL_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("adll assertion failed");

// next-cycle implication
`define ADLL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("adll assertion failed");

`endif

// File: hw/rtl/adll_pkg.sv
// ----------------------------------------------------------------------------
// adll_pkg
// Shared codes, control word layout and microprogram of the linked list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adll_pkg;

   localparam int NODES_DEFAULT = 1024;
   localparam int DATA_W        = 32;
   localparam int ACT_W         = 3;
   localparam int STAT_W        = 2;
   localparam int UPC_W         = 4;

   // actions
   localparam logic [ACT_W-1:0] ACT_HEAD   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_TAIL   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_LEFT   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_RIGHT  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd4;
   localparam logic [ACT_W-1:0] ACT_READ   = 3'd5;

   // status
   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

   typedef logic [UPC_W-1:0] upc_type;

   // microprogram addresses
   localparam upc_type UPC_IDLE     = 4'd0;
   localparam upc_type UPC_DONE     = 4'd1;
   localparam upc_type UPC_HEAD_A   = 4'd2;
   localparam upc_type UPC_HEAD_B   = 4'd3;
   localparam upc_type UPC_TAIL_A   = 4'd4;
   localparam upc_type UPC_TAIL_B   = 4'd5;
   localparam upc_type UPC_LEFT_A   = 4'd6;
   localparam upc_type UPC_LEFT_B   = 4'd7;
   localparam upc_type UPC_RIGHT_A  = 4'd8;
   localparam upc_type UPC_RIGHT_B  = 4'd9;
   localparam upc_type UPC_REM_ALL  = 4'd10;
   localparam upc_type UPC_REM_HEAD = 4'd11;
   localparam upc_type UPC_REM_TAIL = 4'd12;
   localparam upc_type UPC_REM_MID  = 4'd13;

   // link sources for store addresses and data
   typedef enum logic [2:0] {
      SRC_NIL,
      SRC_N,
      SRC_K,
      SRC_P,
      SRC_Q,
      SRC_HEAD,
      SRC_TAIL
   } src_type;

   // register updates
   typedef enum logic [2:0] {
      RU_NONE,
      RU_HEAD_INS,
      RU_TAIL_INS,
      RU_BUMP,
      RU_CLEAR,
      RU_HEAD_Q,
      RU_TAIL_P
   } ru_type;

   typedef enum logic [1:0] {
      J_DISPATCH,
      J_SEQ,
      J_END
   } jump_type;

   typedef struct packed {
      logic     val_we;
      logic     prev_we;
      src_type  prev_addr;
      src_type  prev_data;
      logic     next_we;
      src_type  next_addr;
      src_type  next_data;
      ru_type   reg_op;
      jump_type jump;
   } ctl_type;

   typedef struct packed {
      logic val;
      logic prev;
      logic next;
   } store_we_type;

   function automatic ctl_type ucode(input upc_type upc);
      ctl_type c;
      c = '{val_we: 1'b0, prev_we: 1'b0, prev_addr: SRC_NIL, prev_data: SRC_NIL,
            next_we: 1'b0, next_addr: SRC_NIL, next_data: SRC_NIL,
            reg_op: RU_NONE, jump: J_END};
      unique case (upc)
         UPC_IDLE: begin
            c.jump = J_DISPATCH;
         end
         UPC_DONE: begin
            c.jump = J_END;
         end
         UPC_HEAD_A: begin
            c.val_we = 1'b1;
            c.prev_we = 1'b1; c.prev_addr = SRC_N; c.prev_data = SRC_NIL;
            c.next_we = 1'b1; c.next_addr = SRC_N; c.next_data = SRC_HEAD;
            c.jump = J_SEQ;
         end
         UPC_HEAD_B: begin
            c.prev_we = 1'b1; c.prev_addr = SRC_HEAD; c.prev_data = SRC_N;
            c.reg_op = RU_HEAD_INS;
         end
         UPC_TAIL_A: begin
            c.val_we = 1'b1;
            c.next_we = 1'b1; c.next_addr = SRC_N; c.next_data = SRC_NIL;
            c.prev_we = 1'b1; c.prev_addr = SRC_N; c.prev_data = SRC_TAIL;
            c.jump = J_SEQ;
         end
         UPC_TAIL_B: begin
            c.next_we = 1'b1; c.next_addr = SRC_TAIL; c.next_data = SRC_N;
            c.reg_op = RU_TAIL_INS;
         end
         UPC_LEFT_A: begin
            c.val_we = 1'b1;
            c.next_we = 1'b1; c.next_addr = SRC_N; c.next_data = SRC_K;
            c.prev_we = 1'b1; c.prev_addr = SRC_N; c.prev_data = SRC_P;
            c.jump = J_SEQ;
         end
         UPC_LEFT_B: begin
            c.next_we = 1'b1; c.next_addr = SRC_P; c.next_data = SRC_N;
            c.prev_we = 1'b1; c.prev_addr = SRC_K; c.prev_data = SRC_N;
            c.reg_op = RU_BUMP;
         end
         UPC_RIGHT_A: begin
            c.val_we = 1'b1;
            c.next_we = 1'b1; c.next_addr = SRC_N; c.next_data = SRC_Q;
            c.prev_we = 1'b1; c.prev_addr = SRC_N; c.prev_data = SRC_K;
            c.jump = J_SEQ;
         end
         UPC_RIGHT_B: begin
            c.prev_we = 1'b1; c.prev_addr = SRC_Q; c.prev_data = SRC_N;
            c.next_we = 1'b1; c.next_addr = SRC_K; c.next_data = SRC_N;
            c.reg_op = RU_BUMP;
         end
         UPC_REM_ALL: begin
            c.reg_op = RU_CLEAR;
         end
         UPC_REM_HEAD: begin
            c.prev_we = 1'b1; c.prev_addr = SRC_Q; c.prev_data = SRC_NIL;
            c.reg_op = RU_HEAD_Q;
         end
         UPC_REM_TAIL: begin
            c.next_we = 1'b1; c.next_addr = SRC_P; c.next_data = SRC_NIL;
            c.reg_op = RU_TAIL_P;
         end
         UPC_REM_MID: begin
            c.next_we = 1'b1; c.next_addr = SRC_P; c.next_data = SRC_Q;
            c.prev_we = 1'b1; c.prev_addr = SRC_Q; c.prev_data = SRC_P;
         end
         default: begin
            c.jump = J_END;
         end
      endcase
      return c;
   endfunction

endpackage

// File: hw/rtl/adll_if.sv
// ----------------------------------------------------------------------------
// adll_if
// Valid/ready channels for list commands and their results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface adll_req_if import adll_pkg::*; #(
   parameter int NODES = NODES_DEFAULT
);
   localparam int IDX_W = $clog2(NODES);

   logic                     valid;
   logic                     ready;
   logic [ACT_W-1:0]         action;
   logic [IDX_W-1:0]         node;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output action, output node, output value, input ready);
   modport sink   (input valid, input action, input node, input value, output ready);
endinterface

interface adll_rsp_if import adll_pkg::*; #(
   parameter int NODES = NODES_DEFAULT
);
   localparam int IDX_W  = $clog2(NODES);
   localparam int LINK_W = $clog2(NODES + 1);

   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic [IDX_W-1:0]         new_node;
   logic [LINK_W-1:0]        head_node;
   logic [LINK_W-1:0]        tail_node;
   logic signed [DATA_W-1:0] read_value;
   logic [LINK_W-1:0]        read_prev;
   logic [LINK_W-1:0]        read_next;

   modport source (output valid, output status, output new_node, output head_node,
                   output tail_node, output read_value, output read_prev,
                   output read_next, input ready);
   modport sink   (input valid, input status, input new_node, input head_node,
                   input tail_node, input read_value, input read_prev,
                   input read_next, output ready);
endinterface

// File: hw/rtl/adll_store.sv
// ----------------------------------------------------------------------------
// adll_store
// Node value, previous link and next link memories; one write port each and
// a shared registered read of all three at one address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adll_store import adll_pkg::*; #(
   parameter int NODES = NODES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             rd_en,
   input  logic [$clog2(NODES)-1:0]         rd_addr,
   input  store_we_type                     we,
   input  logic [$clog2(NODES)-1:0]         val_addr,
   input  logic [DATA_W-1:0]                val_data,
   input  logic [$clog2(NODES)-1:0]         prev_addr,
   input  logic [$clog2(NODES+1)-1:0]       prev_data,
   input  logic [$clog2(NODES)-1:0]         next_addr,
   input  logic [$clog2(NODES+1)-1:0]       next_data,
   output logic [DATA_W-1:0]                rd_value,
   output logic [$clog2(NODES+1)-1:0]       rd_prev,
   output logic [$clog2(NODES+1)-1:0]       rd_next
);

   localparam int LINK_W = $clog2(NODES + 1);

   logic [DATA_W-1:0] val_mem  [NODES];
   logic [LINK_W-1:0] prev_mem [NODES];
   logic [LINK_W-1:0] next_mem [NODES];

   always_ff @(posedge clock) begin
      if (we.val) begin
         val_mem[val_addr] <= val_data;
      end
      if (rd_en) begin
         rd_value <= val_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (we.prev) begin
         prev_mem[prev_addr] <= prev_data;
      end
      if (rd_en) begin
         rd_prev <= prev_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (we.next) begin
         next_mem[next_addr] <= next_data;
      end
      if (rd_en) begin
         rd_next <= next_mem[rd_addr];
      end
   end

endmodule

// File: hw/rtl/array_doubly_linked_list.sv
// Doubly linked list over three node memories with a bump allocator. Each
// request beat carries one command; each yields exactly one response beat
// with the status and the head and tail after the command. An insert runs as
// an accept step with neighbor read and then two write steps, since each link
// memory has a single write port and an insert can touch two entries of one;
// remove, read and rejected commands run as the accept step and a final step.
// The response register lets the next command be accepted while a result is
// still waiting; the final step of a command holds only if that register is
// still occupied. The node memories are not reset and need no clearing pass.
// ----------------------------------------------------------------------------
// array_doubly_linked_list
// Top level: command decode, microcode sequencer, head/tail/free registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "array_doubly_linked_list_macros.svh"

module array_doubly_linked_list import adll_pkg::*; #(
   parameter int NODES = NODES_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   adll_req_if.sink   req_bus,
   adll_rsp_if.source rsp_bus
);

   localparam int IDX_W  = $clog2(NODES);
   localparam int LINK_W = $clog2(NODES + 1);
   localparam logic [LINK_W-1:0] NIL = LINK_W'(NODES);

   // sequencer
   upc_type upc_ff, upc_in;
   ctl_type ctl;

   // list state
   logic [LINK_W-1:0] head_ff, head_in;
   logic [LINK_W-1:0] tail_ff, tail_in;
   logic [LINK_W-1:0] next_free_ff, next_free_in;

   // per-command operands, captured on accept
   logic [IDX_W-1:0]  k_ff;
   logic [DATA_W-1:0] val_ff;
   logic [STAT_W-1:0] status_ff;
   logic              ins_ff;
   logic              rd_ff;

   // response register
   logic                     rsp_valid_ff;
   logic [STAT_W-1:0]        rsp_status_ff;
   logic [IDX_W-1:0]         rsp_new_node_ff;
   logic [LINK_W-1:0]        rsp_head_ff;
   logic [LINK_W-1:0]        rsp_tail_ff;
   logic [DATA_W-1:0]        rsp_value_ff;
   logic [LINK_W-1:0]        rsp_prev_ff;
   logic [LINK_W-1:0]        rsp_next_ff;

   // decode
   upc_type           disp_upc;
   logic [STAT_W-1:0] disp_status;
   logic              disp_ins;
   logic              disp_rd;
   logic [LINK_W-1:0] node_ext;

   // datapath
   logic              fire;
   logic              out_busy;
   logic              stall;
   logic              advance;
   logic              load_out;
   store_we_type      we;
   logic [LINK_W-1:0] prev_addr, prev_data, next_addr, next_data;
   logic [DATA_W-1:0] rd_value;
   logic [LINK_W-1:0] rd_prev, rd_next;

   assign ctl      = ucode(upc_ff);
   assign fire     = req_bus.valid & req_bus.ready;
   assign out_busy = rsp_valid_ff & ~rsp_bus.ready;
   assign stall    = (ctl.jump == J_END) & out_busy;
   assign advance  = ~stall;
   assign load_out = (ctl.jump == J_END) & ~out_busy;
   assign node_ext = LINK_W'(req_bus.node);

   assign req_bus.ready = (upc_ff == UPC_IDLE);

   // Command decode. The bad-node check wins over the full check. Insert
   // left of the head and right of the tail fold into head/tail inserts;
   // remove picks its routine from the head/tail compare up front.
   always_comb begin
      logic needs_node;
      logic inserts;
      needs_node  = (req_bus.action == ACT_LEFT) || (req_bus.action == ACT_RIGHT) ||
                    (req_bus.action == ACT_REMOVE) || (req_bus.action == ACT_READ);
      inserts     = (req_bus.action == ACT_HEAD) || (req_bus.action == ACT_TAIL) ||
                    (req_bus.action == ACT_LEFT) || (req_bus.action == ACT_RIGHT);
      disp_upc    = UPC_DONE;
      disp_status = STAT_OK;
      disp_ins    = 1'b0;
      disp_rd     = 1'b0;
      priority if (needs_node && (node_ext >= next_free_ff)) begin
         disp_status = STAT_BAD;
      end else if (inserts && (next_free_ff == NIL)) begin
         disp_status = STAT_FULL;
      end else begin
         disp_ins = inserts;
         unique case (req_bus.action)
            ACT_HEAD:  disp_upc = UPC_HEAD_A;
            ACT_TAIL:  disp_upc = UPC_TAIL_A;
            ACT_LEFT:  disp_upc = (node_ext == head_ff) ? UPC_HEAD_A : UPC_LEFT_A;
            ACT_RIGHT: disp_upc = (node_ext == tail_ff) ? UPC_TAIL_A : UPC_RIGHT_A;
            ACT_REMOVE: begin
               priority if (head_ff == tail_ff) begin
                  disp_upc = UPC_REM_ALL;
               end else if (node_ext == head_ff) begin
                  disp_upc = UPC_REM_HEAD;
               end else if (node_ext == tail_ff) begin
                  disp_upc = UPC_REM_TAIL;
               end else begin
                  disp_upc = UPC_REM_MID;
               end
            end
            ACT_READ:  disp_rd = 1'b1;
            default:   disp_upc = UPC_DONE;
         endcase
      end
   end

   // step counter
   always_comb begin
      unique case (ctl.jump)
         J_DISPATCH: upc_in = fire ? disp_upc : UPC_IDLE;
         J_SEQ:      upc_in = upc_type'(upc_ff + 1'b1);
         J_END:      upc_in = stall ? upc_ff : UPC_IDLE;
         default:    upc_in = UPC_IDLE;
      endcase
   end

   function automatic logic [LINK_W-1:0] link_src(input src_type sel);
      logic [LINK_W-1:0] r;
      unique case (sel)
         SRC_NIL:  r = NIL;
         SRC_N:    r = next_free_ff;
         SRC_K:    r = LINK_W'(k_ff);
         SRC_P:    r = rd_prev;
         SRC_Q:    r = rd_next;
         SRC_HEAD: r = head_ff;
         SRC_TAIL: r = tail_ff;
         default:  r = NIL;
      endcase
      return r;
   endfunction

   // Store writes. A write aimed at "none" is dropped, which covers every
   // neighbor update that would go through an empty link.
   always_comb begin
      prev_addr = link_src(ctl.prev_addr);
      prev_data = link_src(ctl.prev_data);
      next_addr = link_src(ctl.next_addr);
      next_data = link_src(ctl.next_data);
      we.val    = ctl.val_we & advance;
      we.prev   = ctl.prev_we & advance & (prev_addr < NIL);
      we.next   = ctl.next_we & advance & (next_addr < NIL);
   end

   // head, tail and allocator updates, applied on the last step
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      next_free_in = next_free_ff;
      if (advance) begin
         unique case (ctl.reg_op)
            RU_NONE: begin
            end
            RU_HEAD_INS: begin
               head_in      = next_free_ff;
               next_free_in = next_free_ff + 1'b1;
               if (head_ff == NIL) begin
                  tail_in = next_free_ff;
               end
            end
            RU_TAIL_INS: begin
               tail_in      = next_free_ff;
               next_free_in = next_free_ff + 1'b1;
               if (tail_ff == NIL) begin
                  head_in = next_free_ff;
               end
            end
            RU_BUMP: begin
               next_free_in = next_free_ff + 1'b1;
            end
            RU_CLEAR: begin
               head_in = NIL;
               tail_in = NIL;
            end
            RU_HEAD_Q: begin
               head_in = rd_next;
            end
            RU_TAIL_P: begin
               tail_in = rd_prev;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UPC_IDLE;
         head_ff      <= NIL;
         tail_ff      <= NIL;
         next_free_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         next_free_ff <= next_free_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         k_ff      <= req_bus.node;
         val_ff    <= req_bus.value;
         status_ff <= disp_status;
         ins_ff    <= disp_ins;
         rd_ff     <= disp_rd;
      end
      if (load_out) begin
         rsp_status_ff   <= status_ff;
         rsp_new_node_ff <= ins_ff ? next_free_ff[IDX_W-1:0] : '0;
         rsp_head_ff     <= head_in;
         rsp_tail_ff     <= tail_in;
         rsp_value_ff    <= rd_ff ? rd_value : '0;
         rsp_prev_ff     <= rd_ff ? rd_prev : '0;
         rsp_next_ff     <= rd_ff ? rd_next : '0;
      end
   end

   // target node is read during the accept cycle; data is ready for step A
   adll_store #(
      .NODES(NODES)
   ) u_store (
      .clock     (clock),
      .rd_en     (fire),
      .rd_addr   (req_bus.node),
      .we        (we),
      .val_addr  (next_free_ff[IDX_W-1:0]),
      .val_data  (val_ff),
      .prev_addr (prev_addr[IDX_W-1:0]),
      .prev_data (prev_data),
      .next_addr (next_addr[IDX_W-1:0]),
      .next_data (next_data),
      .rd_value  (rd_value),
      .rd_prev   (rd_prev),
      .rd_next   (rd_next)
   );

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.new_node   = rsp_new_node_ff;
   assign rsp_bus.head_node  = rsp_head_ff;
   assign rsp_bus.tail_node  = rsp_tail_ff;
   assign rsp_bus.read_value = signed'(rsp_value_ff);
   assign rsp_bus.read_prev  = rsp_prev_ff;
   assign rsp_bus.read_next  = rsp_next_ff;

   // allocator never passes the store size
   `ADLL_ASSERT_IMP(a_free_bound, 1'b1, next_free_ff <= NIL)
   // allocator moves by at most one per cycle
   `ADLL_ASSERT_NEXT(a_free_step, 1'b1,
      next_free_ff == $past(next_free_ff) || next_free_ff == $past(next_free_ff) + 1'b1)
   // a rejected command leaves the allocator alone
   `ADLL_ASSERT_NEXT(a_reject_keeps, load_out && status_ff != STAT_OK, next_free_ff == $past(next_free_ff))
   // no store write while waiting for a command
   `ADLL_ASSERT_IMP(a_idle_no_write, upc_ff == UPC_IDLE, !we.val && !we.prev && !we.next)
   // failed commands hand out no node
   `ADLL_ASSERT_IMP(a_fail_no_node, rsp_bus.valid && rsp_bus.status != STAT_OK, rsp_bus.new_node == '0)

endmodule

// File: tb/array_doubly_linked_list_tb.sv
// ----------------------------------------------------------------------------
// array_doubly_linked_list_tb
// Self-checking bench for the array doubly linked list. Commands go in as
// request beats with random gaps while the response side stalls at random.
// A software copy of the node stores, head, tail and free counter predicts
// every response beat, which is compared field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module array_doubly_linked_list_tb;
   import adll_pkg::*;

   localparam int LIST_NODES  = NODES_DEFAULT;
   localparam int STALL_LIMIT = 4000;   // cycles without any beat before giving up
   localparam int RANDOM_CMDS = 1900;

   // link value meaning "none" / list empty
   localparam logic [10:0] NIL_LINK = 11'(LIST_NODES);

   // action codes the block treats as no-ops
   localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [9:0]        new_node;
      logic [10:0]       head;
      logic [10:0]       tail;
      logic [31:0]       rd_value;
      logic [10:0]       rd_prev;
      logic [10:0]       rd_next;
   } list_outcome_type;

   logic clock;
   logic reset;

   adll_req_if #(.NODES(LIST_NODES)) req_bus ();
   adll_rsp_if #(.NODES(LIST_NODES)) rsp_bus ();

   array_doubly_linked_list #(.NODES(LIST_NODES)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // ------------------------------------------------------------------------
   // Shadow copy of the list. Entries are only read once allocated, exactly
   // as the hardware is expected to behave.
   // ------------------------------------------------------------------------
   logic [31:0] mdl_value [LIST_NODES];
   logic [10:0] mdl_prev  [LIST_NODES];
   logic [10:0] mdl_next  [LIST_NODES];
   logic [10:0] mdl_head = NIL_LINK;
   logic [10:0] mdl_tail = NIL_LINK;
   logic [10:0] mdl_free = '0;

   list_outcome_type pending_outcomes [$];   // predicted response beats, oldest first
   logic [9:0]       live_nodes [$];         // nodes believed to be in the list
   int               mismatch_count = 0;
   bit               no_gaps = 1'b0;         // burst stretch: sender never idles

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // bump allocator: node gets its value, counter moves on
   function automatic logic [10:0] grab_node(input logic [31:0] val);
      logic [10:0] n;
      n = mdl_free;
      mdl_value[n] = val;
      mdl_free = mdl_free + 11'd1;
      return n;
   endfunction

   function automatic logic [10:0] alloc_head(input logic [31:0] val);
      logic [10:0] n;
      n = grab_node(val);
      mdl_prev[n] = NIL_LINK;
      if (mdl_head >= NIL_LINK) begin
         mdl_next[n] = NIL_LINK;
         mdl_tail = n;
      end else begin
         mdl_next[n] = mdl_head;
         mdl_prev[mdl_head] = n;
      end
      mdl_head = n;
      return n;
   endfunction

   function automatic logic [10:0] alloc_tail(input logic [31:0] val);
      logic [10:0] n;
      n = grab_node(val);
      mdl_next[n] = NIL_LINK;
      if (mdl_tail >= NIL_LINK) begin
         mdl_prev[n] = NIL_LINK;
         mdl_head = n;
      end else begin
         mdl_prev[n] = mdl_tail;
         mdl_next[mdl_tail] = n;
      end
      mdl_tail = n;
      return n;
   endfunction

   // Applies one command to the shadow list and returns the response it
   // should produce. Removed nodes keep their stale links and are used as-is.
   function automatic list_outcome_type apply_list_cmd(input logic [ACT_W-1:0] act,
                                                       input logic [9:0] idx,
                                                       input logic [31:0] val);
      list_outcome_type o;
      logic [10:0]      k, n, p, q;
      logic             uses_node, is_insert;
      o = '0;
      n = '0;
      k = {1'b0, idx};
      uses_node = (act >= ACT_LEFT) && (act <= ACT_READ);
      is_insert = (act <= ACT_RIGHT);
      // unallocated node wins over a full store
      if (uses_node && k >= mdl_free) begin
         o.status = STAT_BAD;
      end else if (is_insert && mdl_free >= NIL_LINK) begin
         o.status = STAT_FULL;
      end else begin
         o.status = STAT_OK;
         unique case (act)
            ACT_HEAD: begin
               n = alloc_head(val);
            end
            ACT_TAIL: begin
               n = alloc_tail(val);
            end
            ACT_LEFT: begin
               if (k == mdl_head) begin
                  n = alloc_head(val);
               end else begin
                  p = mdl_prev[k];
                  n = grab_node(val);
                  mdl_next[n] = k;
                  mdl_prev[n] = p;
                  if (p < NIL_LINK) mdl_next[p] = n;
                  mdl_prev[k] = n;
               end
            end
            ACT_RIGHT: begin
               if (k == mdl_tail) begin
                  n = alloc_tail(val);
               end else begin
                  q = mdl_next[k];
                  n = grab_node(val);
                  mdl_next[n] = q;
                  mdl_prev[n] = k;
                  if (q < NIL_LINK) mdl_prev[q] = n;
                  mdl_next[k] = n;
               end
            end
            ACT_REMOVE: begin
               p = mdl_prev[k];
               q = mdl_next[k];
               // single-entry (or empty) list: cleared whatever node is named
               if (mdl_head == mdl_tail) begin
                  mdl_head = NIL_LINK;
                  mdl_tail = NIL_LINK;
               end else if (k == mdl_head) begin
                  mdl_head = q;
                  if (q < NIL_LINK) mdl_prev[q] = NIL_LINK;
               end else if (k == mdl_tail) begin
                  mdl_tail = p;
                  if (p < NIL_LINK) mdl_next[p] = NIL_LINK;
               end else begin
                  if (p < NIL_LINK) mdl_next[p] = q;
                  if (q < NIL_LINK) mdl_prev[q] = p;
               end
            end
            ACT_READ: begin
               o.rd_value = mdl_value[k];
               o.rd_prev  = mdl_prev[k];
               o.rd_next  = mdl_next[k];
            end
            default: begin
            end
         endcase
         if (is_insert) o.new_node = n[9:0];
      end
      o.head = mdl_head;
      o.tail = mdl_tail;
      return o;
   endfunction

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] pick_value();
      unique case ($urandom_range(0, 15))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Target node: mostly live nodes, sometimes head/tail for the end-insert
   // shortcuts, some stale ones, and some never allocated.
   function automatic logic [9:0] pick_node(input logic [ACT_W-1:0] act);
      int r;
      r = $urandom_range(0, 99);
      if (act == ACT_LEFT && r < 12 && mdl_head < NIL_LINK) return mdl_head[9:0];
      if (act == ACT_RIGHT && r < 12 && mdl_tail < NIL_LINK) return mdl_tail[9:0];
      if (r < 75 && live_nodes.size() > 0)
         return live_nodes[$urandom_range(0, live_nodes.size() - 1)];
      if (r < 88 && mdl_free > 0) return 10'($urandom_range(0, int'(mdl_free) - 1));
      if (mdl_free < NIL_LINK) return 10'($urandom_range(int'(mdl_free), LIST_NODES - 1));
      return 10'($urandom_range(0, LIST_NODES - 1));
   endfunction

   // One request beat: optional idle gap, then hold valid until accepted.
   // Valid is left high on exit so the next beat can follow without a bubble.
   task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [9:0] idx,
                           input logic [31:0] val);
      int               gap;
      int               i;
      list_outcome_type o;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.action <= act;
      req_bus.node   <= idx;
      req_bus.value  <= val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      o = apply_list_cmd(act, idx, val);
      pending_outcomes.push_back(o);
      // keep the live set roughly in step for target selection
      if (o.status == STAT_OK) begin
         if (act <= ACT_RIGHT) begin
            live_nodes.push_back(o.new_node);
         end else if (act == ACT_REMOVE) begin
            if (o.head == NIL_LINK) begin
               live_nodes.delete();
            end else begin
               i = 0;
               while (i < live_nodes.size() && live_nodes[i] != idx) i++;
               if (i < live_nodes.size()) live_nodes.delete(i);
            end
         end
      end
   endtask

   // Sender goes quiet until every predicted beat has come back.
   task automatic wait_for_outcomes();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() > 0) @(posedge clock);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Directed tests
   // ------------------------------------------------------------------------

   // Empty list: every node-targeting command is rejected; spare codes no-op.
   task automatic test_empty_list();
      send_cmd(ACT_READ, 10'd0, 32'd0);
      send_cmd(ACT_REMOVE, 10'd1023, 32'd0);
      send_cmd(ACT_LEFT, 10'd0, 32'h0000_0001);
      send_cmd(ACT_RIGHT, 10'h2AA, 32'h0000_0002);
      send_cmd(ACT_SPARE_6, 10'h3FF, 32'hFFFF_FFFF);
      send_cmd(ACT_SPARE_7, 10'd0, 32'd0);
   endtask

   // One node in, out, out again, then reuse of its stale links.
   task automatic test_single_node();
      send_cmd(ACT_HEAD, 10'd0, 32'h8000_0000);
      send_cmd(ACT_READ, 10'd0, 32'd0);
      send_cmd(ACT_REMOVE, 10'd0, 32'd0);
      send_cmd(ACT_REMOVE, 10'd0, 32'd0);       // list already empty
      send_cmd(ACT_READ, 10'd0, 32'd0);         // stale node
      send_cmd(ACT_LEFT, 10'd0, 32'h5A5A_5A5A); // insert beside a removed node
      send_cmd(ACT_TAIL, 10'h155, 32'h7FFF_FFFF);
   endtask

   // Plain end inserts, then left-of-head and right-of-tail shortcuts.
   task automatic test_list_ends();
      send_cmd(ACT_HEAD, 10'h3FF, 32'hFFFF_FFFF);
      send_cmd(ACT_TAIL, 10'h000, 32'h0000_0000);
      send_cmd(ACT_LEFT, mdl_head[9:0], 32'h0000_0001);
      send_cmd(ACT_RIGHT, mdl_tail[9:0], 32'h0000_1234);
   endtask

   // Inserts on both sides of an interior node.
   task automatic test_inner_inserts();
      logic [9:0] mid;
      mid = mdl_next[mdl_head][9:0];
      send_cmd(ACT_LEFT, mid, 32'hCAFE_0001);
      send_cmd(ACT_RIGHT, mid, 32'hCAFE_0002);
      send_cmd(ACT_READ, mid, 32'd0);
   endtask

   // Remove head, tail and an interior node; read the removed one.
   task automatic test_remove_cases();
      logic [9:0] mid;
      send_cmd(ACT_REMOVE, mdl_head[9:0], 32'd0);
      send_cmd(ACT_REMOVE, mdl_tail[9:0], 32'd0);
      mid = mdl_next[mdl_head][9:0];
      send_cmd(ACT_REMOVE, mid, 32'd0);
      send_cmd(ACT_READ, mid, 32'd0);
   endtask

   // Random mix weighted toward inserts so the store fills and the full
   // status gets exercised near the end; halfway the sender drains.
   task automatic test_random_traffic(input int count);
      logic [ACT_W-1:0] act;
      logic [9:0]       idx;
      int               r;
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         if (i == count / 2) wait_for_outcomes();
         r = $urandom_range(0, 99);
         if (r < 15)      act = ACT_HEAD;
         else if (r < 30) act = ACT_TAIL;
         else if (r < 45) act = ACT_LEFT;
         else if (r < 60) act = ACT_RIGHT;
         else if (r < 78) act = ACT_REMOVE;
         else if (r < 96) act = ACT_READ;
         else if (r < 98) act = ACT_SPARE_6;
         else             act = ACT_SPARE_7;
         if (act >= ACT_LEFT && act <= ACT_READ) idx = pick_node(act);
         else idx = 10'($urandom);
         send_cmd(act, idx, pick_value());
      end
      no_gaps = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Response side: random backpressure, with occasional long stalls and
   // long stretches of steady ready.
   // ------------------------------------------------------------------------
   initial begin : rsp_backpressure
      int  hold;
      int  r;
      logic rdy;
      hold = 0;
      rdy  = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
               rdy = 1'b1; hold = $urandom_range(100, 300);
            end else if (r < 60) begin
               rdy = 1'b1; hold = $urandom_range(0, 20);
            end else if (r < 92) begin
               rdy = 1'b0; hold = $urandom_range(0, 2);
            end else begin
               rdy = 1'b0; hold = $urandom_range(10, 40);
            end
         end
         rsp_bus.ready <= rdy;
      end
   end

   // Every response beat is matched against the oldest prediction.
   always @(posedge clock) begin : rsp_check
      list_outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: response beat with nothing pending, expected none actual status %0h",
                     $time, rsp_bus.status);
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_bus.status));
            check_field("new_node", 32'(want.new_node), 32'(rsp_bus.new_node));
            check_field("head_node", 32'(want.head), 32'(rsp_bus.head_node));
            check_field("tail_node", 32'(want.tail), 32'(rsp_bus.tail_node));
            check_field("read_value", want.rd_value, rsp_bus.read_value);
            check_field("read_prev", 32'(want.rd_prev), 32'(rsp_bus.read_prev));
            check_field("read_next", 32'(want.rd_next), 32'(rsp_bus.read_next));
         end
      end
   end

   // Watchdog: any beat on either side resets the count.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: watchdog, no beat for %0d cycles", $time, STALL_LIMIT);
      $display("array_doubly_linked_list_tb: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.action <= ACT_HEAD;
      req_bus.node   <= '0;
      req_bus.value  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_single_node();
      test_list_ends();
      test_inner_inserts();
      test_remove_cases();
      test_random_traffic(RANDOM_CMDS);

      // drain, then give a late or extra beat time to show
      wait_for_outcomes();
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && pending_outcomes.size() == 0)
         $display("array_doubly_linked_list_tb: done, clean");
      else
         $display("array_doubly_linked_list_tb: done, errors");
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/adll_pkg.sv
hw/rtl/adll_if.sv
hw/rtl/adll_store.sv
hw/rtl/array_doubly_linked_list.sv
tb/array_doubly_linked_list_tb.sv
